FILE: hw/rtl/plm_pkg.sv
package plm_pkg;

  // fixed field widths
  localparam int MODE_W  = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 7;
  localparam int ST_W    = 2;

  // default list capacity
  localparam int DEPTH_DEF = 64;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR    = 3'd0,
    MODE_INSERT   = 3'd1,
    MODE_DELETE   = 3'd2,
    MODE_SEARCH   = 3'd3,
    MODE_APPEND   = 3'd4,
    MODE_SORT     = 3'd5,
    MODE_TRAVERSE = 3'd6
  } mode_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BADPOS  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

FILE: hw/rtl/plm_ram.sv
module plm_ram import plm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [VAL_W-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [VAL_W-1:0]         rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/positional_list_engine_top.sv
// list engine: one item at a time; stall is high from accept until the item's work is done.
// clear, bad position, full and empty cases, and append at batch end, go straight to the result;
// insert shifts the entries behind the slot and then writes the value; delete shifts entries;
// search scans entries; traverse: one result per cycle when the output is taken; sort: bubble
// passes over a shrinking range; all bound by the one read and one write port of the ram.
// reset: count and batch overflow cleared; entry ram is not cleared, no clearing pass.
module positional_list_engine_top import plm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_batch_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ST_W-1:0]         out_status,
  output logic [POS_W-1:0]        out_where,
  output logic signed [VAL_W-1:0] out_item,
  output logic [CNT_W-1:0]        out_count_after,
  output logic                    out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EMIT    = 9'b000000010,
    S_SH_WR   = 9'b000000100,
    S_INS_WR  = 9'b000001000,
    S_SR_CMP  = 9'b000010000,
    S_TR_OUT  = 9'b000100000,
    S_SO_HEAD = 9'b001000000,
    S_SO_RUN  = 9'b010000000,
    S_SO_TAIL = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             bovf_r, bovf_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             ins_r, ins_nxt;
  logic [VAL_W-1:0] cur_r, cur_nxt;
  status_t          res_status_r, res_status_nxt;
  logic [POS_W-1:0] res_where_r, res_where_nxt;

  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [POS_W-1:0] out_where_r;
  logic [VAL_W-1:0] out_item_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_last_r;

  // ram interface
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_q;

  logic             accept;
  logic             can_emit;
  logic             emit_fire;
  logic             full;
  logic [CNT_W-1:0] ptr_inc, ptr_dec, count_inc, count_dec, pos_dec;

  plm_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && (state_r == S_IDLE);
  assign can_emit   = !out_valid_r || !out_stall;
  assign emit_fire  = can_emit && ((state_r == S_EMIT) || (state_r == S_TR_OUT));
  assign full       = (count_r == DEPTH_CNT);
  assign ptr_inc    = ptr_r + CNT_W'(1);
  assign ptr_dec    = ptr_r - CNT_W'(1);
  assign count_inc  = count_r + CNT_W'(1);
  assign count_dec  = count_r - CNT_W'(1);
  assign pos_dec    = CNT_W'(pos_r) - CNT_W'(1);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    bovf_nxt       = bovf_r;
    ptr_nxt        = ptr_r;
    lim_nxt        = lim_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    ins_nxt        = ins_r;
    cur_nxt        = cur_r;
    res_status_nxt = res_status_r;
    res_where_nxt  = res_where_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt        = in_position;
          val_nxt        = in_value;
          res_status_nxt = ST_OK;
          res_where_nxt  = '0;
          case (in_mode)
            MODE_CLEAR: begin
              count_nxt = '0;
              bovf_nxt  = 1'b0;
              state_nxt = S_EMIT;
            end
            MODE_INSERT: begin
              if (in_position == '0 || in_position > count_inc) begin
                res_status_nxt = ST_BADPOS;
                state_nxt      = S_EMIT;
              end else if (full) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_EMIT;
              end else if (in_position == count_inc) begin
                state_nxt = S_INS_WR;
              end else begin
                // shift right from the tail down to the slot
                ins_nxt   = 1'b1;
                ptr_nxt   = count_dec;
                mem_re    = 1'b1;
                mem_raddr = count_dec[AW-1:0];
                state_nxt = S_SH_WR;
              end
            end
            MODE_DELETE: begin
              if (in_position == '0 || in_position > count_r) begin
                res_status_nxt = ST_BADPOS;
                state_nxt      = S_EMIT;
              end else if (in_position == count_r) begin
                count_nxt = count_dec;
                state_nxt = S_EMIT;
              end else begin
                // shift left from the slot after the deleted one
                ins_nxt   = 1'b0;
                ptr_nxt   = CNT_W'(in_position);
                mem_re    = 1'b1;
                mem_raddr = in_position[AW-1:0];
                state_nxt = S_SH_WR;
              end
            end
            MODE_SEARCH: begin
              if (count_r == '0) begin
                res_status_nxt = ST_MISSING;
                state_nxt      = S_EMIT;
              end else begin
                ptr_nxt   = '0;
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_nxt = S_SR_CMP;
              end
            end
            MODE_APPEND: begin
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_value;
                count_nxt = count_inc;
              end
              if (in_batch_end) begin
                res_status_nxt = (bovf_r || full) ? ST_FULL : ST_OK;
                bovf_nxt       = 1'b0;
                state_nxt      = S_EMIT;
              end else begin
                bovf_nxt = bovf_r | full;
              end
            end
            MODE_SORT: begin
              if (count_r < CNT_W'(2)) begin
                state_nxt = S_EMIT;
              end else begin
                lim_nxt   = count_dec;
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_nxt = S_SO_HEAD;
              end
            end
            MODE_TRAVERSE: begin
              if (count_r == '0) begin
                state_nxt = S_EMIT;
              end else begin
                ptr_nxt   = '0;
                mem_re    = 1'b1;
                mem_raddr = '0;
                state_nxt = S_TR_OUT;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // write the entry read last cycle one slot over, read the next one
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_q;
        if (ins_r) begin
          mem_waddr = ptr_inc[AW-1:0];
          if (ptr_r == pos_dec) begin
            state_nxt = S_INS_WR;
          end else begin
            ptr_nxt   = ptr_dec;
            mem_re    = 1'b1;
            mem_raddr = ptr_dec[AW-1:0];
          end
        end else begin
          mem_waddr = ptr_dec[AW-1:0];
          if (ptr_r == count_dec) begin
            count_nxt = count_dec;
            state_nxt = S_EMIT;
          end else begin
            ptr_nxt   = ptr_inc;
            mem_re    = 1'b1;
            mem_raddr = ptr_inc[AW-1:0];
          end
        end
      end

      // drop the new value into its slot
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_dec[AW-1:0];
        mem_wdata = val_r;
        count_nxt = count_inc;
        state_nxt = S_EMIT;
      end

      // compare one entry per cycle, next read already in flight
      S_SR_CMP: begin
        if (mem_q == val_r) begin
          res_where_nxt = POS_W'(ptr_inc);
          state_nxt     = S_EMIT;
        end else if (ptr_inc == count_r) begin
          res_status_nxt = ST_MISSING;
          state_nxt      = S_EMIT;
        end else begin
          ptr_nxt   = ptr_inc;
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[AW-1:0];
        end
      end

      // one entry per result, read data holds while the output is stalled
      S_TR_OUT: begin
        if (can_emit) begin
          if (ptr_inc == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_inc;
            mem_re    = 1'b1;
            mem_raddr = ptr_inc[AW-1:0];
          end
        end
      end

      // start of a bubble pass: carry the first entry
      S_SO_HEAD: begin
        cur_nxt   = mem_q;
        ptr_nxt   = CNT_W'(1);
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
        state_nxt = S_SO_RUN;
      end

      // keep the larger value carried, settle the smaller one behind it
      S_SO_RUN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_dec[AW-1:0];
        if ($signed(cur_r) > $signed(mem_q)) begin
          mem_wdata = mem_q;
        end else begin
          mem_wdata = cur_r;
          cur_nxt   = mem_q;
        end
        if (ptr_r == lim_r) begin
          state_nxt = S_SO_TAIL;
        end else begin
          ptr_nxt   = ptr_inc;
          mem_re    = 1'b1;
          mem_raddr = ptr_inc[AW-1:0];
        end
      end

      // pass maximum lands at the end of the unsorted range
      S_SO_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = lim_r[AW-1:0];
        mem_wdata = cur_r;
        if (lim_r == CNT_W'(1)) begin
          state_nxt = S_EMIT;
        end else begin
          lim_nxt   = lim_r - CNT_W'(1);
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = S_SO_HEAD;
        end
      end

      S_EMIT: begin
        if (can_emit) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      bovf_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bovf_r  <= bovf_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    lim_r        <= lim_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    ins_r        <= ins_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_where_r  <= res_where_nxt;
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_count_r <= count_r;
      if (state_r == S_TR_OUT) begin
        out_status_r <= ST_OK;
        out_where_r  <= POS_W'(ptr_inc);
        out_item_r   <= mem_q;
        out_last_r   <= (ptr_inc == count_r);
      end else begin
        out_status_r <= res_status_r;
        out_where_r  <= res_where_r;
        out_item_r   <= '0;
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_where       = out_where_r;
  assign out_item        = out_item_r;
  assign out_count_after = out_count_r;
  assign out_last        = out_last_r;

endmodule

FILE: tb/list_engine_checker.sv
module list_engine_checker import plm_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_batch_end,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [ST_W-1:0]         out_status,
  input  logic [POS_W-1:0]        out_where,
  input  logic signed [VAL_W-1:0] out_item,
  input  logic [CNT_W-1:0]        out_count_after,
  input  logic                    out_last,
  output int                      fail_count,
  output int                      results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                 status;
    logic [POS_W-1:0]        where;
    logic signed [VAL_W-1:0] item;
    logic [CNT_W-1:0]        count_after;
    logic                    last;
  } list_result_t;

  // shadow copy of the list
  logic signed [VAL_W-1:0] slots [DEPTH];
  int                      n_entries;
  bit                      batch_spill;
  list_result_t            awaited_results [$];

  function automatic void await_result(status_t st, logic [POS_W-1:0] wh,
                                       logic signed [VAL_W-1:0] it, logic lst);
    list_result_t r;
    r.status      = st;
    r.where       = wh;
    r.item        = it;
    r.count_after = CNT_W'(n_entries);
    r.last        = lst;
    awaited_results.push_back(r);
  endfunction

  // apply one operation to the shadow list and queue what it should produce
  function automatic void predict_list_op(logic [MODE_W-1:0] op, logic [POS_W-1:0] pos,
                                          logic signed [VAL_W-1:0] val, logic bend);
    int                      hit;
    logic signed [VAL_W-1:0] swap;
    case (op)
      MODE_CLEAR: begin
        n_entries   = 0;
        batch_spill = 1'b0;
        await_result(ST_OK, '0, '0, 1'b1);
      end
      MODE_INSERT: begin
        if (int'(pos) < 1 || int'(pos) > n_entries + 1) begin
          await_result(ST_BADPOS, '0, '0, 1'b1);
        end else if (n_entries >= DEPTH) begin
          await_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          for (int i = n_entries; i >= int'(pos); i--) slots[i] = slots[i-1];
          slots[int'(pos)-1] = val;
          n_entries++;
          await_result(ST_OK, '0, '0, 1'b1);
        end
      end
      MODE_DELETE: begin
        if (int'(pos) < 1 || int'(pos) > n_entries) begin
          await_result(ST_BADPOS, '0, '0, 1'b1);
        end else begin
          for (int i = int'(pos) - 1; i + 1 < n_entries; i++) slots[i] = slots[i+1];
          n_entries--;
          await_result(ST_OK, '0, '0, 1'b1);
        end
      end
      MODE_SEARCH: begin
        // walk downward so the lowest match wins
        hit = 0;
        for (int i = n_entries - 1; i >= 0; i--) if (slots[i] == val) hit = i + 1;
        if (hit != 0) await_result(ST_OK, POS_W'(hit), '0, 1'b1);
        else await_result(ST_MISSING, '0, '0, 1'b1);
      end
      MODE_APPEND: begin
        if (n_entries < DEPTH) begin
          slots[n_entries] = val;
          n_entries++;
        end else begin
          batch_spill = 1'b1;
        end
        if (bend) begin
          await_result(batch_spill ? ST_FULL : ST_OK, '0, '0, 1'b1);
          batch_spill = 1'b0;
        end
      end
      MODE_SORT: begin
        // ascending, signed
        for (int i = 0; i + 1 < n_entries; i++) begin
          for (int j = 0; j + 1 < n_entries - i; j++) begin
            if (slots[j] > slots[j+1]) begin
              swap       = slots[j];
              slots[j]   = slots[j+1];
              slots[j+1] = swap;
            end
          end
        end
        await_result(ST_OK, '0, '0, 1'b1);
      end
      MODE_TRAVERSE: begin
        if (n_entries == 0) await_result(ST_OK, '0, '0, 1'b1);
        for (int i = 0; i < n_entries; i++)
          await_result(ST_OK, POS_W'(i + 1), slots[i], i + 1 == n_entries);
      end
      default: ;
    endcase
  endfunction

  // compare accepted results, then fold in accepted items
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      n_entries   = 0;
      batch_spill = 1'b0;
      fail_count  = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.status      = status_t'(out_status);
        got.where       = out_where;
        got.item        = out_item;
        got.count_after = out_count_after;
        got.last        = out_last;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status %0d where %0d item %0d count %0d last %0d",
                   $time, got.status, got.where, got.item, got.count_after, got.last);
          fail_count = fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected status %0d where %0d item %0d count %0d last %0d",
                     $time, want.status, want.where, want.item, want.count_after, want.last);
            $display("%0t:           actual status %0d where %0d item %0d count %0d last %0d",
                     $time, got.status, got.where, got.item, got.count_after, got.last);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict_list_op(in_mode, in_position, in_value, in_batch_end);
    end
    results_outstanding <= awaited_results.size();
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import plm_pkg::*;

  localparam int LIST_DEPTH     = DEPTH_DEF;
  localparam int DIRECTED_ITEMS = 24;
  localparam int RANDOM_ITEMS   = 500;
  localparam int HOLD_CYCLES    = 400;
  // sized to cover a full sort with a wide margin
  localparam int QUIET_LIMIT    = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    in_valid        = 1'b0;
  logic                    in_stall;
  logic [MODE_W-1:0]       in_mode         = MODE_CLEAR;
  logic [POS_W-1:0]        in_position     = '0;
  logic signed [VAL_W-1:0] in_value        = '0;
  logic                    in_batch_end    = 1'b0;
  logic                    out_valid;
  logic                    out_stall       = 1'b0;
  logic [ST_W-1:0]         out_status;
  logic [POS_W-1:0]        out_where;
  logic signed [VAL_W-1:0] out_item;
  logic [CNT_W-1:0]        out_count_after;
  logic                    out_last;

  int fail_count;
  int results_outstanding;
  bit idle_on       = 1'b1;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;
  int est_len       = 0;

  positional_list_engine_top #(.DEPTH(LIST_DEPTH)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_position     (in_position),
    .in_value        (in_value),
    .in_batch_end    (in_batch_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_where       (out_where),
    .out_item        (out_item),
    .out_count_after (out_count_after),
    .out_last        (out_last)
  );

  list_engine_checker #(.DEPTH(LIST_DEPTH)) i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_position         (in_position),
    .in_value            (in_value),
    .in_batch_end        (in_batch_end),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_where           (out_where),
    .out_item            (out_item),
    .out_count_after     (out_count_after),
    .out_last            (out_last),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 34);
    end
  end

  // watchdog on cycles with no traffic on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 15)) - 8;
      1: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // offer one item and hold it until accepted; tracks the list length loosely
  task automatic offer_list_op(logic [MODE_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] val, logic bend);
    if (idle_on) begin
      while ($urandom_range(0, 99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_mode      <= op;
    in_position  <= pos;
    in_value     <= val;
    in_batch_end <= bend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (op)
      MODE_CLEAR:  est_len = 0;
      MODE_INSERT: if (pos >= 1 && int'(pos) <= est_len + 1 && est_len < LIST_DEPTH) est_len++;
      MODE_DELETE: if (pos >= 1 && int'(pos) <= est_len) est_len--;
      MODE_APPEND: if (est_len < LIST_DEPTH) est_len++;
      default: ;
    endcase
    if (op != MODE_RESERVED) items_sent++;
  endtask

  task automatic append_run(int len, bit closed);
    for (int k = 0; k < len; k++)
      offer_list_op(MODE_APPEND, POS_W'($urandom_range(0, 127)), rand_value(),
                    closed && k == len - 1);
  endtask

  // stop offering until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  // position that is usually legal for the current length
  function automatic logic [POS_W-1:0] pick_pos(int span);
    if (span < 1 || $urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 127));
    return POS_W'($urandom_range(1, span));
  endfunction

  initial begin
    bit hold_issued;
    bit drain_issued;
    int pick;
    hold_issued  = 1'b0;
    drain_issued = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, edges of position and value, batches
    offer_list_op(MODE_TRAVERSE, 0, 0, 0);
    offer_list_op(MODE_INSERT, 0, 1, 0);
    offer_list_op(MODE_DELETE, 1, 0, 0);
    offer_list_op(MODE_SEARCH, 0, 0, 0);
    offer_list_op(MODE_INSERT, 1, 32'sh7fff_ffff, 0);
    offer_list_op(MODE_INSERT, 1, 32'sh8000_0000, 0);
    offer_list_op(MODE_INSERT, 3, 5, 0);
    offer_list_op(MODE_INSERT, 2, -1, 1);
    offer_list_op(MODE_INSERT, 127, 9, 0);
    offer_list_op(MODE_SEARCH, 0, 5, 0);
    offer_list_op(MODE_SEARCH, 0, 32'sh8000_0000, 0);
    offer_list_op(MODE_SORT, 0, 0, 0);
    offer_list_op(MODE_TRAVERSE, 0, 0, 0);
    offer_list_op(MODE_DELETE, 127, 0, 0);
    offer_list_op(MODE_DELETE, 2, 0, 0);
    offer_list_op(MODE_APPEND, 0, 7, 0);
    offer_list_op(MODE_APPEND, 0, -7, 1);
    offer_list_op(MODE_RESERVED, 127, -1, 1);
    // batch interrupted by another operation
    offer_list_op(MODE_APPEND, 0, 3, 0);
    offer_list_op(MODE_DELETE, 1, 0, 0);
    offer_list_op(MODE_APPEND, 0, 9, 1);
    offer_list_op(MODE_TRAVERSE, 0, 0, 0);
    offer_list_op(MODE_CLEAR, 127, -1, 1);
    offer_list_op(MODE_TRAVERSE, 0, 0, 0);

    // fill past capacity, then insert into the full list
    append_run(LIST_DEPTH + 2, 1'b1);
    offer_list_op(MODE_INSERT, POS_W'($urandom_range(1, LIST_DEPTH + 1)), rand_value(), 0);
    offer_list_op(MODE_TRAVERSE, 0, 0, 0);
    offer_list_op(MODE_CLEAR, 0, 0, 0);

    // random operation mix, mostly legal positions
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      idle_on <= !(items_sent >= DIRECTED_ITEMS + 200 && items_sent < DIRECTED_ITEMS + 300);
      if (!hold_issued && items_sent >= DIRECTED_ITEMS + 100) begin
        hold_issued = 1'b1;
        hold_requests <= hold_requests + 1;
      end
      if (!drain_issued && items_sent >= DIRECTED_ITEMS + 350) begin
        drain_issued = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // batch: mostly short, sometimes long enough to overflow, sometimes left open
        append_run(($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 10),
                   $urandom_range(0, 9) != 0);
      end else if (pick < 45) begin
        offer_list_op(MODE_INSERT, pick_pos(est_len + 1), rand_value(),
                      1'($urandom_range(0, 1)));
      end else if (pick < 60) begin
        offer_list_op(MODE_DELETE, pick_pos(est_len), rand_value(), 1'($urandom_range(0, 1)));
      end else if (pick < 72) begin
        offer_list_op(MODE_SEARCH, POS_W'($urandom_range(0, 127)), rand_value(),
                      1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
        offer_list_op(MODE_SORT, POS_W'($urandom_range(0, 127)), rand_value(),
                      1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        offer_list_op(MODE_TRAVERSE, POS_W'($urandom_range(0, 127)), rand_value(),
                      1'($urandom_range(0, 1)));
      end else if (pick < 97) begin
        offer_list_op(MODE_CLEAR, POS_W'($urandom_range(0, 127)), rand_value(),
                      1'($urandom_range(0, 1)));
      end else begin
        offer_list_op(MODE_RESERVED, POS_W'($urandom_range(0, 127)), rand_value(),
                      1'($urandom_range(0, 1)));
      end
    end

    // wait out the last results, then a quiet stretch for strays
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/plm_pkg.sv
hw/rtl/plm_ram.sv
hw/rtl/positional_list_engine_top.sv
tb/list_engine_checker.sv
tb/testbench.sv
